// ===== hw/rtl/pic_pkg.sv =====
`default_nettype none

package pic_pkg;

  // source count and arbitration tree shape
  localparam int NUM_SOURCES = 28;
  localparam int SRC_W       = 5;
  localparam int LVL_W       = 4;
  localparam int PRIO_W      = 16;
  localparam int TREE_DEPTH  = $clog2(NUM_SOURCES);
  localparam int TREE_LEAVES = 1 << TREE_DEPTH;

  // apb register map
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // fixed levels of the three external lines, one nibble each
  localparam logic [PRIO_W-1:0] FIXED_LEVELS = 16'h0246;

  // all sources enabled out of reset
  localparam logic [NUM_SOURCES-1:0] ENABLE_RESET = '1;

  typedef enum logic [2:0] {
    MODE_QUERY     = 3'd0,
    MODE_SET_PEND  = 3'd1,
    MODE_CLR_PEND  = 3'd2,
    MODE_ENABLE    = 3'd3,
    MODE_DISABLE   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_PRIO_A = 2'd0,
    REG_PRIO_B = 2'd1,
    REG_PRIO_C = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    BANK_FIXED = 2'd0,
    BANK_A     = 2'd1,
    BANK_B     = 2'd2,
    BANK_C     = 2'd3
  } bank_t;

  // which register holds each source's priority, and at which nibble
  localparam bank_t PRIO_BANK [NUM_SOURCES] = '{
    BANK_FIXED, BANK_FIXED, BANK_FIXED, BANK_C, BANK_C, BANK_C, BANK_C,
    BANK_C, BANK_C, BANK_C, BANK_A, BANK_A, BANK_A, BANK_A,
    BANK_A, BANK_A, BANK_A, BANK_B, BANK_B, BANK_B, BANK_B,
    BANK_C, BANK_C, BANK_C, BANK_C, BANK_B, BANK_B, BANK_A
  };

  localparam logic [3:0] PRIO_SHIFT [NUM_SOURCES] = '{
    4'd0, 4'd4, 4'd8, 4'd0, 4'd12, 4'd8, 4'd8,
    4'd8, 4'd8, 4'd8, 4'd12, 4'd8, 4'd4, 4'd4,
    4'd0, 4'd0, 4'd0, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd12, 4'd8, 4'd8
  };

  typedef struct packed {
    logic [PRIO_W-1:0] a;
    logic [PRIO_W-1:0] b;
    logic [PRIO_W-1:0] c;
  } prio_regs_t;

  // snapshot of one item after its pending/enable update
  typedef struct packed {
    logic [NUM_SOURCES-1:0] active;
    logic                   blk;
    logic [LVL_W-1:0]       mask_level;
  } item_t;

  // priority level of one source (idx is a constant at every call)
  function automatic logic [LVL_W-1:0] src_level(input int idx, input prio_regs_t p);
    logic [PRIO_W-1:0] word;
    case (PRIO_BANK[idx])
      BANK_A:  word = p.a;
      BANK_B:  word = p.b;
      BANK_C:  word = p.c;
      default: word = FIXED_LEVELS;
    endcase
    return word[PRIO_SHIFT[idx] +: LVL_W];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/priority_interrupt_controller_core.sv =====
// each input transfer passes through the snapshot stage and then the result register
// throughput: one item per cycle while out_ready holds, one pass through the 28-way level compare tree
// an input transfer is taken while the result register drains in the same cycle
// reset: synchronous, active high; pending bits clear, enable bits set,
// priority registers zero, both pipeline stages empty
`default_nettype none

module priority_interrupt_controller_core
  import pic_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        mode,
  input  wire logic [SRC_W-1:0]  source,
  input  wire logic              cpu_block,
  input  wire logic [LVL_W-1:0]  cpu_mask_level,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   request,
  output logic [SRC_W-1:0]       winner_source,
  output logic [LVL_W-1:0]       winner_level,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  prio_regs_t prio;
  item_t      s1_item;
  logic       s1_valid;
  logic       advance;

  // priority registers
  pic_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .prio    (prio)
  );

  // pending/enable update and snapshot
  pic_state u_state (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .source         (source),
    .cpu_block      (cpu_block),
    .cpu_mask_level (cpu_mask_level),
    .advance        (advance),
    .s1_valid       (s1_valid),
    .s1_item        (s1_item)
  );

  // winner select and result register
  pic_arbiter u_arb (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1_item       (s1_item),
    .prio          (prio),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .request       (request),
    .winner_source (winner_source),
    .winner_level  (winner_level)
  );

  // a request always names a nonzero level and a real source
  a_req_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && request |-> (winner_level != '0) && (winner_source < SRC_W'(NUM_SOURCES)))
    else $error("request with bad winner");

  // no request reports zeros
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !request |-> (winner_level == '0) && (winner_source == '0))
    else $error("no request but winner fields set");

  // the input side never stalls while the snapshot stage is empty
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with empty snapshot stage");

  // a blocked item never requests
  a_block: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance && s1_item.blk |=> out_valid && !request)
    else $error("request while cpu blocked");

endmodule

`default_nettype wire

// ===== hw/rtl/pic_cfg.sv =====
`default_nettype none

module pic_cfg
  import pic_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output prio_regs_t             prio
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // register writes, out-of-range index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      prio <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_PRIO_A: prio.a <= pwdata[PRIO_W-1:0];
        REG_PRIO_B: prio.b <= pwdata[PRIO_W-1:0];
        REG_PRIO_C: prio.c <= pwdata[PRIO_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_PRIO_A: prdata = DATA_W'(prio.a);
      REG_PRIO_B: prdata = DATA_W'(prio.b);
      REG_PRIO_C: prdata = DATA_W'(prio.c);
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pic_state.sv =====
`default_nettype none

module pic_state
  import pic_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       mode,
  input  wire logic [SRC_W-1:0] source,
  input  wire logic             cpu_block,
  input  wire logic [LVL_W-1:0] cpu_mask_level,
  input  wire logic             advance,
  output logic                  s1_valid,
  output item_t                 s1_item
);

  logic [NUM_SOURCES-1:0] pending;
  logic [NUM_SOURCES-1:0] pending_next;
  logic [NUM_SOURCES-1:0] enable;
  logic [NUM_SOURCES-1:0] enable_next;
  logic [NUM_SOURCES-1:0] bit_sel;
  logic                   in_range;
  logic                   xfer;

  // the snapshot stage frees up when its item moves into the result register
  assign in_ready = !s1_valid || advance;
  assign xfer     = in_valid && in_ready;
  assign in_range = source < SRC_W'(NUM_SOURCES);
  assign bit_sel  = NUM_SOURCES'(1) << source;

  // one pending/enable operation per item
  always_comb begin
    pending_next = pending;
    enable_next  = enable;
    if (in_range) begin
      case (mode_t'(mode))
        MODE_SET_PEND: pending_next = pending | bit_sel;
        MODE_CLR_PEND: pending_next = pending & ~bit_sel;
        MODE_ENABLE:   enable_next  = enable | bit_sel;
        MODE_DISABLE:  enable_next  = enable & ~bit_sel;
        default: ;
      endcase
    end
  end

  // source state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      enable  <= ENABLE_RESET;
    end else if (xfer) begin
      pending <= pending_next;
      enable  <= enable_next;
    end
  end

  // snapshot stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // snapshot payload
  always_ff @(posedge clk) begin
    if (xfer) begin
      s1_item.active     <= pending_next & enable_next;
      s1_item.blk        <= cpu_block;
      s1_item.mask_level <= cpu_mask_level;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pic_arbiter.sv =====
`default_nettype none

module pic_arbiter
  import pic_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s1_valid,
  input  wire item_t       s1_item,
  input  wire prio_regs_t  prio,
  output logic             advance,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             request,
  output logic [SRC_W-1:0] winner_source,
  output logic [LVL_W-1:0] winner_level
);

  logic [LVL_W-1:0] node_lvl [TREE_DEPTH+1][TREE_LEAVES];
  logic [SRC_W-1:0] node_src [TREE_DEPTH+1][TREE_LEAVES];
  logic [LVL_W-1:0] src_lvl;
  logic [LVL_W-1:0] best_lvl;
  logic [SRC_W-1:0] best_src;

  assign advance = !out_valid || out_ready;

  // leaves hold the level of each eligible source, zero when not eligible,
  // then the compare tree picks the upper index on equal level
  always_comb begin
    src_lvl = '0;
    for (int i = 0; i < TREE_LEAVES; i++) begin
      node_src[0][i] = SRC_W'(i);
      node_lvl[0][i] = '0;
    end
    for (int i = 0; i < NUM_SOURCES; i++) begin
      src_lvl = src_level(i, prio);
      if (s1_item.active[i] && !s1_item.blk && (src_lvl > s1_item.mask_level)) begin
        node_lvl[0][i] = src_lvl;
      end
    end
    for (int k = 1; k <= TREE_DEPTH; k++) begin
      for (int j = 0; j < TREE_LEAVES; j++) begin
        node_lvl[k][j] = '0;
        node_src[k][j] = '0;
      end
      for (int j = 0; j < (TREE_LEAVES >> k); j++) begin
        if (node_lvl[k-1][2*j+1] >= node_lvl[k-1][2*j]) begin
          node_lvl[k][j] = node_lvl[k-1][2*j+1];
          node_src[k][j] = node_src[k-1][2*j+1];
        end else begin
          node_lvl[k][j] = node_lvl[k-1][2*j];
          node_src[k][j] = node_src[k-1][2*j];
        end
      end
    end
  end

  assign best_lvl = node_lvl[TREE_DEPTH][0];
  assign best_src = (best_lvl != '0) ? node_src[TREE_DEPTH][0] : '0;

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      request       <= best_lvl != '0;
      winner_source <= best_src;
      winner_level  <= best_lvl;
    end
  end

endmodule

`default_nettype wire
